// ===== design/dam_pkg.sv =====
`default_nettype none

package dam_pkg;

   localparam int MAX_NODES_DEF = 64;

   localparam int NODE_W   = 6;
   localparam int NCOUNT_W = 7;
   localparam int DEG_W    = 6;
   localparam int LINKS_W  = 12;
   localparam int STATUS_W = 3;
   localparam int REQ_W    = 16;
   localparam int RSP_W    = 32;

   typedef enum logic [1:0] {
      FUNC_ADD   = 2'd0,
      FUNC_DEL   = 2'd1,
      FUNC_QUERY = 2'd2,
      FUNC_CLEAR = 2'd3
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 3'd0,
      STATUS_RANGE   = 3'd1,
      STATUS_SELF    = 3'd2,
      STATUS_PRESENT = 3'd3,
      STATUS_ABSENT  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_SWEEP,
      S_IDLE,
      S_CALC
   } state_type;

endpackage

`default_nettype wire

// ===== design/dam_ram.sv =====
`default_nettype none

module dam_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== design/directed_adjacency_matrix_unit.sv =====
// Directed graph link store with per-node in/out degree counters.
// req channel (req_tvalid/req_tready/req_tdata) takes one word per operation:
// add link, delete link, query link or clear all. rsp channel returns exactly
// one word per request with status, link presence after the operation,
// in-degree of the target, out-degree of the source and the total link count.
// csr channel (csr_valid/csr_ready/csr_data) sets the node count; a write
// wipes every link and counter. Write it only while no request is in flight.
// Add, delete and query read the row memory (target row plus its in-degree)
// and the out-degree memory when the word is accepted, then update and
// write back in the update cycle. Clear all wipes one row per cycle
// through the single write port of each memory, then returns its result.
// After reset and after every csr write the same wipe runs with req_tready
// low. The result sits in an output register; while the
// receiver stalls the next request is still accepted and read, and the block
// holds in its update cycle until the output register frees up.
`default_nettype none

module directed_adjacency_matrix_unit #(
   parameter int MAX_NODES = dam_pkg::MAX_NODES_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   // [1:0] func, [7:2] to_node, [13:8] from_node, [15:14] zero
   input  wire logic [dam_pkg::REQ_W-1:0]     req_tdata,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // [2:0] status, [3] link_present, [9:4] in_degree, [15:10] out_degree,
   // [27:16] link_count, [31:28] zero
   output logic      [dam_pkg::RSP_W-1:0]     rsp_tdata,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [dam_pkg::NCOUNT_W-1:0]  csr_data
);

   localparam int AW    = $clog2(MAX_NODES);
   localparam int ROW_W = MAX_NODES + dam_pkg::DEG_W;

   dam_pkg::state_type state_ff, state_in;

   logic [AW-1:0]                   sweep_ff, sweep_in;
   logic                            pend_ff, pend_in;
   dam_pkg::func_type               func_ff, func_in;
   logic [dam_pkg::NODE_W-1:0]      to_ff, to_in;
   logic [dam_pkg::NODE_W-1:0]      from_ff, from_in;
   logic [dam_pkg::NCOUNT_W-1:0]    ncount_ff, ncount_in;
   logic [dam_pkg::LINKS_W-1:0]     total_ff, total_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   dam_pkg::status_type             rsp_status_ff, rsp_status_in;
   logic                            rsp_present_ff, rsp_present_in;
   logic [dam_pkg::DEG_W-1:0]       rsp_in_deg_ff, rsp_in_deg_in;
   logic [dam_pkg::DEG_W-1:0]       rsp_out_deg_ff, rsp_out_deg_in;
   logic [dam_pkg::LINKS_W-1:0]     rsp_count_ff, rsp_count_in;

   dam_pkg::func_type               req_func;
   logic [dam_pkg::NODE_W-1:0]      req_to;
   logic [dam_pkg::NODE_W-1:0]      req_from;
   logic                            req_fire;
   logic                            csr_fire;
   logic                            out_free;
   logic                            sweep_last;

   logic                            row_we;
   logic [AW-1:0]                   row_waddr;
   logic [ROW_W-1:0]                row_wdata;
   logic [AW-1:0]                   row_raddr;
   logic [ROW_W-1:0]                row_rdata;
   logic                            odeg_we;
   logic [AW-1:0]                   odeg_waddr;
   logic [dam_pkg::DEG_W-1:0]       odeg_wdata;
   logic [AW-1:0]                   odeg_raddr;
   logic [dam_pkg::DEG_W-1:0]       odeg_rdata;

   logic [AW-1:0]                   to_idx;
   logic [AW-1:0]                   from_idx;
   logic [MAX_NODES-1:0]            row_old;
   logic [MAX_NODES-1:0]            row_mask;
   logic [MAX_NODES-1:0]            row_new;
   logic [dam_pkg::DEG_W-1:0]       in_deg_old;
   logic [dam_pkg::DEG_W-1:0]       in_deg_new;
   logic [dam_pkg::DEG_W-1:0]       out_deg_new;
   logic [dam_pkg::LINKS_W-1:0]     total_new;
   logic                            bit_old;
   logic                            to_ok;
   logic                            from_ok;
   logic                            do_add;
   logic                            do_del;
   logic                            present_new;
   dam_pkg::status_type             status_new;

   assign req_func   = dam_pkg::func_type'(req_tdata[1:0]);
   assign req_to     = req_tdata[7:2];
   assign req_from   = req_tdata[13:8];
   assign req_tready = (state_ff == dam_pkg::S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign csr_fire   = csr_valid && csr_ready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign sweep_last = (sweep_ff == AW'(MAX_NODES - 1));

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_count_ff, rsp_out_deg_ff, rsp_in_deg_ff,
                        rsp_present_ff, rsp_status_ff};

   // operand decode for the update cycle
   assign to_idx     = AW'(to_ff);
   assign from_idx   = AW'(from_ff);
   assign row_old    = row_rdata[MAX_NODES-1:0];
   assign in_deg_old = row_rdata[MAX_NODES +: dam_pkg::DEG_W];
   assign row_mask   = MAX_NODES'(1) << from_idx;
   assign bit_old    = |(row_old & row_mask);
   assign to_ok      = ({1'b0, to_ff} < ncount_ff) && (32'(to_ff) < 32'(MAX_NODES));
   assign from_ok    = ({1'b0, from_ff} < ncount_ff) && (32'(from_ff) < 32'(MAX_NODES));

   always_comb begin
      status_new = dam_pkg::STATUS_OK;
      do_add     = 1'b0;
      do_del     = 1'b0;
      priority if (func_ff == dam_pkg::FUNC_CLEAR) begin
         status_new = dam_pkg::STATUS_OK;
      end else if (!to_ok || !from_ok) begin
         status_new = dam_pkg::STATUS_RANGE;
      end else if (func_ff == dam_pkg::FUNC_ADD) begin
         priority if (to_ff == from_ff) begin
            status_new = dam_pkg::STATUS_SELF;
         end else if (bit_old) begin
            status_new = dam_pkg::STATUS_PRESENT;
         end else begin
            do_add = 1'b1;
         end
      end else if (func_ff == dam_pkg::FUNC_DEL) begin
         if (!bit_old) begin
            status_new = dam_pkg::STATUS_ABSENT;
         end else begin
            do_del = 1'b1;
         end
      end else begin
         status_new = dam_pkg::STATUS_OK;
      end
   end

   always_comb begin
      row_new     = row_old;
      in_deg_new  = in_deg_old;
      out_deg_new = odeg_rdata;
      total_new   = total_ff;
      present_new = bit_old;
      if (do_add) begin
         row_new     = row_old | row_mask;
         in_deg_new  = in_deg_old + dam_pkg::DEG_W'(1);
         out_deg_new = odeg_rdata + dam_pkg::DEG_W'(1);
         total_new   = total_ff + dam_pkg::LINKS_W'(1);
         present_new = 1'b1;
      end else if (do_del) begin
         row_new     = row_old & ~row_mask;
         in_deg_new  = in_deg_old - dam_pkg::DEG_W'(1);
         out_deg_new = odeg_rdata - dam_pkg::DEG_W'(1);
         total_new   = total_ff - dam_pkg::LINKS_W'(1);
         present_new = 1'b0;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dam_pkg::S_SWEEP: begin
            if (sweep_last) begin
               state_in = pend_ff ? dam_pkg::S_CALC : dam_pkg::S_IDLE;
            end
         end
         dam_pkg::S_IDLE: begin
            if (req_fire) begin
               state_in = (req_func == dam_pkg::FUNC_CLEAR) ? dam_pkg::S_SWEEP
                                                            : dam_pkg::S_CALC;
            end
         end
         dam_pkg::S_CALC: begin
            if (out_free) begin
               state_in = dam_pkg::S_IDLE;
            end
         end
         default: state_in = dam_pkg::S_SWEEP;
      endcase
      if (csr_fire) begin
         state_in = dam_pkg::S_SWEEP;
      end
   end

   // datapath and memory controls
   always_comb begin
      sweep_in       = sweep_ff;
      pend_in        = pend_ff;
      func_in        = func_ff;
      to_in          = to_ff;
      from_in        = from_ff;
      ncount_in      = ncount_ff;
      total_in       = total_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_status_in  = rsp_status_ff;
      rsp_present_in = rsp_present_ff;
      rsp_in_deg_in  = rsp_in_deg_ff;
      rsp_out_deg_in = rsp_out_deg_ff;
      rsp_count_in   = rsp_count_ff;
      row_we         = 1'b0;
      row_waddr      = to_idx;
      row_wdata      = {in_deg_new, row_new};
      odeg_we        = 1'b0;
      odeg_waddr     = from_idx;
      odeg_wdata     = out_deg_new;
      row_raddr      = (state_ff == dam_pkg::S_IDLE) ? AW'(req_to) : to_idx;
      odeg_raddr     = (state_ff == dam_pkg::S_IDLE) ? AW'(req_from) : from_idx;

      unique case (state_ff)
         dam_pkg::S_SWEEP: begin
            row_we     = 1'b1;
            row_waddr  = sweep_ff;
            row_wdata  = '0;
            odeg_we    = 1'b1;
            odeg_waddr = sweep_ff;
            odeg_wdata = '0;
            sweep_in   = sweep_ff + AW'(1);
         end
         dam_pkg::S_IDLE: begin
            if (req_fire) begin
               func_in = req_func;
               to_in   = req_to;
               from_in = req_from;
               if (req_func == dam_pkg::FUNC_CLEAR) begin
                  sweep_in = '0;
                  pend_in  = 1'b1;
                  total_in = '0;
               end
            end
         end
         dam_pkg::S_CALC: begin
            if (out_free) begin
               pend_in        = 1'b0;
               row_we         = do_add || do_del;
               odeg_we        = do_add || do_del;
               total_in       = total_new;
               rsp_valid_in   = 1'b1;
               rsp_status_in  = status_new;
               if (func_ff == dam_pkg::FUNC_CLEAR) begin
                  rsp_present_in = 1'b0;
                  rsp_in_deg_in  = '0;
                  rsp_out_deg_in = '0;
                  rsp_count_in   = '0;
               end else begin
                  rsp_present_in = to_ok && from_ok && present_new;
                  rsp_in_deg_in  = to_ok ? in_deg_new : '0;
                  rsp_out_deg_in = from_ok ? out_deg_new : '0;
                  rsp_count_in   = total_new;
               end
            end
         end
         default: begin
            sweep_in = '0;
         end
      endcase

      if (csr_fire) begin
         ncount_in = csr_data;
         sweep_in  = '0;
         pend_in   = 1'b0;
         total_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dam_pkg::S_SWEEP;
         sweep_ff     <= '0;
         pend_ff      <= 1'b0;
         ncount_ff    <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         pend_ff      <= pend_in;
         ncount_ff    <= ncount_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff        <= func_in;
      to_ff          <= to_in;
      from_ff        <= from_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_present_ff <= rsp_present_in;
      rsp_in_deg_ff  <= rsp_in_deg_in;
      rsp_out_deg_ff <= rsp_out_deg_in;
      rsp_count_ff   <= rsp_count_in;
   end

   dam_ram #(
      .WIDTH (ROW_W),
      .DEPTH (MAX_NODES)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (row_we),
      .wr_addr (row_waddr),
      .wr_data (row_wdata),
      .rd_addr (row_raddr),
      .rd_data (row_rdata)
   );

   dam_ram #(
      .WIDTH (dam_pkg::DEG_W),
      .DEPTH (MAX_NODES)
   ) u_odeg_ram (
      .clock   (clock),
      .wr_en   (odeg_we),
      .wr_addr (odeg_waddr),
      .wr_data (odeg_wdata),
      .rd_addr (odeg_raddr),
      .rd_data (odeg_rdata)
   );

   a_csr_starts_wipe: assert property (@(posedge clock) disable iff (reset)
      csr_fire |=> (state_ff == dam_pkg::S_SWEEP) && (total_ff == '0))
      else $error("csr write did not start a wipe");

   a_wipe_count_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dam_pkg::S_SWEEP) |-> (total_ff == '0))
      else $error("link count nonzero during wipe");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dam_pkg::S_IDLE) |-> (!row_we && !odeg_we))
      else $error("memory write outside update or wipe");

   a_clear_result: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == dam_pkg::S_CALC) && out_free && (func_ff == dam_pkg::FUNC_CLEAR)
       && !csr_fire)
      |=> rsp_valid_ff && (rsp_count_ff == '0) && (rsp_status_ff == dam_pkg::STATUS_OK))
      else $error("clear result not all zero");

   a_calc_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_func != dam_pkg::FUNC_CLEAR) && !csr_fire)
      |=> (state_ff == dam_pkg::S_CALC))
      else $error("accepted request did not reach update cycle");

endmodule

`default_nettype wire
